// ----- src/newsgroup_name_byte_checker_assert.svh -----
// assertion macros used by the name byte checker's port-level checker
`ifndef NEWSGROUP_NAME_BYTE_CHECKER_ASSERT_SVH
`define NEWSGROUP_NAME_BYTE_CHECKER_ASSERT_SVH

// same-cycle implication, off during reset
`define NNBC_ASSERT_NOW(label, clk, rst, cond, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
    else $error("name byte checker assertion failed");

// next-cycle implication, off during reset
`define NNBC_ASSERT_NEXT(label, clk, rst, cond, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
    else $error("name byte checker assertion failed");

`endif

// ----- src/nnbc_pkg.sv -----
// types and fault codes of the newsgroup name byte checker
package nnbc_pkg;

  localparam logic [2:0] FAULT_NONE  = 3'd0;
  localparam logic [2:0] FAULT_ASCII = 3'd1;
  localparam logic [2:0] FAULT_LEAD  = 3'd2;
  localparam logic [2:0] FAULT_CONT  = 3'd3;
  localparam logic [2:0] FAULT_TRUNC = 3'd4;
  localparam logic [2:0] FAULT_EMPTY = 3'd5;

  typedef struct packed {
    logic [7:0] name_byte;
    logic       no_byte;
    logic       end_of_name;
  } byte_item_t;

  typedef struct packed {
    logic       name_valid;
    logic [2:0] fault_kind;
  } verdict_item_t;

endpackage

// ----- src/newsgroup_name_byte_checker.sv -----
// Newsgroup name byte checker: takes one byte item per cycle while not stalled and gives one
// verdict per name. A byte item is taken every cycle that the byte side does not stall. When
// it ends a name, the item sits in the input register and the check then loads the verdict
// register, which offers it on the verdict channel. The per-byte check (charset ranges,
// lead decode, a two-bit count of owed continuation bytes and the first fault) sits between
// those two registers. The byte side stalls only while a verdict waits to be taken and the
// held item ends a name; items that do not end a name keep flowing past a waiting verdict.
module newsgroup_name_byte_checker (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  byte_valid,
  output logic                  byte_stall,
  input  nnbc_pkg::byte_item_t  byte_item,
  output logic                  verdict_valid,
  input  logic                  verdict_stall,
  output nnbc_pkg::verdict_item_t verdict_item
);
  import nnbc_pkg::*;

  localparam logic [7:0] LEAD2_LO = 8'hC2;
  localparam logic [7:0] LEAD2_HI = 8'hDF;
  localparam logic [7:0] LEAD3_LO = 8'hE0;
  localparam logic [7:0] LEAD3_HI = 8'hEF;
  localparam logic [7:0] LEAD4_LO = 8'hF0;
  localparam logic [7:0] LEAD4_HI = 8'hF4;

  function automatic logic ascii_allowed(input logic [7:0] b);
    return (b >= 8'h22 && b <= 8'h29) ||
           (b == 8'h2B) ||
           (b >= 8'h2D && b <= 8'h3E) ||
           (b >= 8'h40 && b <= 8'h5A) ||
           (b >= 8'h5E && b <= 8'h7E);
  endfunction

  logic          held_full;
  byte_item_t    held;
  logic [1:0]    expected;
  logic [2:0]    first_fault;
  logic          any_byte_seen;
  logic          verdict_full;
  verdict_item_t verdict;

  logic [1:0]    expected_next;
  logic [2:0]    first_fault_next;
  logic          any_byte_seen_next;
  logic [2:0]    final_fault;
  logic          advance;

  // held item moves on unless it ends a name and a verdict is still stuck
  assign advance    = held_full && (!held.end_of_name || !verdict_full || !verdict_stall);
  assign byte_stall = held_full && !advance;

  assign verdict_valid = verdict_full;
  assign verdict_item  = verdict;

  always_comb begin
    expected_next      = expected;
    first_fault_next   = first_fault;
    any_byte_seen_next = any_byte_seen;
    if (!held.no_byte) begin
      any_byte_seen_next = 1'b1;
      if (expected != 2'd0) begin
        if (held.name_byte[7:6] == 2'b10) begin
          expected_next = expected - 2'd1;
        end else begin
          // sequence dropped, byte not reused as a lead
          expected_next = 2'd0;
          if (first_fault == FAULT_NONE) first_fault_next = FAULT_CONT;
        end
      end else if (!held.name_byte[7]) begin
        if (!ascii_allowed(held.name_byte) && first_fault == FAULT_NONE) begin
          first_fault_next = FAULT_ASCII;
        end
      end else if (held.name_byte >= LEAD2_LO && held.name_byte <= LEAD2_HI) begin
        expected_next = 2'd1;
      end else if (held.name_byte >= LEAD3_LO && held.name_byte <= LEAD3_HI) begin
        expected_next = 2'd2;
      end else if (held.name_byte >= LEAD4_LO && held.name_byte <= LEAD4_HI) begin
        expected_next = 2'd3;
      end else if (first_fault == FAULT_NONE) begin
        first_fault_next = FAULT_LEAD;
      end
    end
    final_fault = first_fault_next;
    if (first_fault_next == FAULT_NONE) begin
      if (!any_byte_seen_next) begin
        final_fault = FAULT_EMPTY;
      end else if (expected_next != 2'd0) begin
        final_fault = FAULT_TRUNC;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held_full     <= 1'b0;
      verdict_full  <= 1'b0;
      expected      <= 2'd0;
      first_fault   <= FAULT_NONE;
      any_byte_seen <= 1'b0;
    end else begin
      if (byte_valid && !byte_stall) begin
        held_full <= 1'b1;
      end else if (advance) begin
        held_full <= 1'b0;
      end

      if (advance && held.end_of_name) begin
        verdict_full  <= 1'b1;
        expected      <= 2'd0;
        first_fault   <= FAULT_NONE;
        any_byte_seen <= 1'b0;
      end else begin
        if (!verdict_stall) verdict_full <= 1'b0;
        if (advance) begin
          expected      <= expected_next;
          first_fault   <= first_fault_next;
          any_byte_seen <= any_byte_seen_next;
        end
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (byte_valid && !byte_stall) held <= byte_item;
    if (advance && held.end_of_name) begin
      verdict.name_valid <= (final_fault == FAULT_NONE);
      verdict.fault_kind <= final_fault;
    end
  end

endmodule

// ----- src/nnbc_checker.sv -----
// port-level assertions for the newsgroup name byte checker, bound to the top level
`include "newsgroup_name_byte_checker_assert.svh"

module nnbc_checker (
  input logic                    clk,
  input logic                    rst,
  input logic                    byte_valid,
  input logic                    byte_stall,
  input nnbc_pkg::byte_item_t    byte_item,
  input logic                    verdict_valid,
  input logic                    verdict_stall,
  input nnbc_pkg::verdict_item_t verdict_item
);
  import nnbc_pkg::*;

  // verdict flag agrees with the fault code
  `NNBC_ASSERT_NOW(a_valid_matches_fault, clk, rst, verdict_valid, verdict_item.name_valid == (verdict_item.fault_kind == FAULT_NONE))

  // only defined fault codes leave the block
  `NNBC_ASSERT_NOW(a_fault_code_known, clk, rst, verdict_valid, verdict_item.fault_kind <= FAULT_EMPTY)

  // with no verdict waiting the byte side never stalls
  `NNBC_ASSERT_NOW(a_no_stall_when_empty, clk, rst, !verdict_valid, !byte_stall)

  // a fresh verdict traces back to an earlier end-of-name transfer on the byte side
  `NNBC_ASSERT_NOW(a_verdict_from_end, clk, rst, $rose(verdict_valid), $past(byte_valid && !byte_stall && byte_item.end_of_name, 2))

  // a stalled verdict holds
  `NNBC_ASSERT_NEXT(a_verdict_holds, clk, rst, verdict_valid && verdict_stall, verdict_valid && $stable(verdict_item))

endmodule

bind newsgroup_name_byte_checker nnbc_checker u_checker (.*);
